### sv/yuv2rgb_pkg.sv
`timescale 1ns / 1ps

package yuv2rgb_pkg;

  typedef logic [7:0] sample_t;

  localparam int K_W = 18;
  localparam int P_W = 27;
  localparam int T_W = 12;
  localparam int M_W = 30;
  localparam int FRAC_BITS = 16;

  typedef logic signed [P_W-1:0] prod_t;
  typedef logic signed [T_W-1:0] tval_t;
  typedef logic signed [M_W-1:0] gain_t;

  localparam logic signed [K_W-1:0] K_V_TO_R = 18'sd89858;
  localparam logic signed [K_W-1:0] K_V_TO_G = -18'sd45773;
  localparam logic signed [K_W-1:0] K_U_TO_G = -18'sd22014;
  localparam logic signed [K_W-1:0] K_U_TO_B = 18'sd113618;
  localparam logic signed [K_W-1:0] K_Y_GAIN = 18'sd76283;
  localparam logic signed [K_W-1:0] ONE_HALF = 18'sd32768;

  localparam logic signed [8:0]     CHROMA_ZERO = 9'sd128;
  localparam logic signed [T_W-1:0] LUMA_FLOOR  = 12'sd16;
  localparam logic signed [M_W-1:0] CHAN_MAX    = 30'sd255;

  function automatic logic signed [8:0] centre(sample_t c);
    return $signed({1'b0, c}) - CHROMA_ZERO;
  endfunction

  function automatic prod_t chroma_mul(logic signed [8:0] c, logic signed [K_W-1:0] k);
    return P_W'(c) * P_W'(k);
  endfunction

  // round the chroma term to an integer offset and add luma
  function automatic tval_t add_luma(sample_t y, prod_t p);
    prod_t s;
    s = (p + P_W'(ONE_HALF)) >>> FRAC_BITS;
    return T_W'(s) + T_W'($signed({1'b0, y}));
  endfunction

  function automatic gain_t luma_gain(tval_t t);
    tval_t d;
    d = t - LUMA_FLOOR;
    return M_W'(d) * M_W'(K_Y_GAIN);
  endfunction

  function automatic sample_t round_clamp(gain_t m);
    gain_t j;
    j = (m + M_W'(ONE_HALF)) >>> FRAC_BITS;
    if (j[M_W-1]) begin
      return 8'd0;
    end else if (j > CHAN_MAX) begin
      return 8'd255;
    end else begin
      return j[7:0];
    end
  endfunction

endpackage

### sv/yuv2rgb_if.sv
`timescale 1ns / 1ps

interface yuv2rgb_in_if;
  logic                 valid;
  logic                 ready;
  yuv2rgb_pkg::sample_t luma;
  yuv2rgb_pkg::sample_t chroma_blue;
  yuv2rgb_pkg::sample_t chroma_red;

  modport source (output valid, output luma, output chroma_blue, output chroma_red,
                  input ready);
  modport sink   (input valid, input luma, input chroma_blue, input chroma_red,
                  output ready);
endinterface

interface yuv2rgb_out_if;
  logic                 valid;
  logic                 ready;
  yuv2rgb_pkg::sample_t red;
  yuv2rgb_pkg::sample_t green;
  yuv2rgb_pkg::sample_t blue;

  modport source (output valid, output red, output green, output blue, input ready);
  modport sink   (input valid, input red, input green, input blue, output ready);
endinterface

### sv/yuv_to_rgb_pixel.sv
// yuv_to_rgb_pixel: BT.601 Y'CbCr to 8-bit RGB converter, 16.16 fixed point.
// in_word  (sink)   : one luma / chroma_blue / chroma_red word per handshake,
//                     taken at a rising edge with valid and ready both high.
// out_word (source) : one red / green / blue word for every input word,
//                     in the order the inputs were taken.
// Pipeline of four register stages: chroma multiplies, rounding plus luma add,
// luma gain multiply, rounding and clamp into the output register.
// Each word moves through the stages in order and is shown from the output register.
// Throughput: one word per clock while out_word.ready stays high; every
// product has its own multiplier in its stage, so every cycle can carry a word.
// When the receiver stalls, the output register holds its word and each stage
// keeps its word until the stage after it frees up; empty stages still fill,
// so in_word.ready drops only once all four stages hold a word.
// Reset (rst_n low, synchronous) empties the pipeline; no word is in flight
// afterwards and out_word.valid is low.
`timescale 1ns / 1ps

module yuv_to_rgb_pixel (
  input  logic         clk,
  input  logic         rst_n,
  yuv2rgb_in_if.sink   in_word,
  yuv2rgb_out_if.source out_word
);

  logic v1_r, v2_r, v3_r, v4_r;
  logic en1, en2, en3, en4;

  // stage 1: chroma products
  yuv2rgb_pkg::sample_t y1_r;
  yuv2rgb_pkg::prod_t   pr1_r, pgv1_r, pgu1_r, pb1_r;
  // stage 2: luma plus offset
  yuv2rgb_pkg::tval_t   tr2_r, tg2_r, tb2_r;
  // stage 3: luma gain products
  yuv2rgb_pkg::gain_t   mr3_r, mg3_r, mb3_r;
  // stage 4: output word
  yuv2rgb_pkg::sample_t r4_r, g4_r, b4_r;

  assign en4 = !v4_r || out_word.ready;
  assign en3 = !v3_r || en4;
  assign en2 = !v2_r || en3;
  assign en1 = !v1_r || en2;

  assign in_word.ready = en1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else begin
      if (en1) v1_r <= in_word.valid;
      if (en2) v2_r <= v1_r;
      if (en3) v3_r <= v2_r;
      if (en4) v4_r <= v3_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en1) begin
      y1_r   <= in_word.luma;
      pr1_r  <= yuv2rgb_pkg::chroma_mul(yuv2rgb_pkg::centre(in_word.chroma_red),
                                        yuv2rgb_pkg::K_V_TO_R);
      pgv1_r <= yuv2rgb_pkg::chroma_mul(yuv2rgb_pkg::centre(in_word.chroma_red),
                                        yuv2rgb_pkg::K_V_TO_G);
      pgu1_r <= yuv2rgb_pkg::chroma_mul(yuv2rgb_pkg::centre(in_word.chroma_blue),
                                        yuv2rgb_pkg::K_U_TO_G);
      pb1_r  <= yuv2rgb_pkg::chroma_mul(yuv2rgb_pkg::centre(in_word.chroma_blue),
                                        yuv2rgb_pkg::K_U_TO_B);
    end
    if (en2) begin
      tr2_r <= yuv2rgb_pkg::add_luma(y1_r, pr1_r);
      tg2_r <= yuv2rgb_pkg::add_luma(y1_r, pgv1_r + pgu1_r);
      tb2_r <= yuv2rgb_pkg::add_luma(y1_r, pb1_r);
    end
    if (en3) begin
      mr3_r <= yuv2rgb_pkg::luma_gain(tr2_r);
      mg3_r <= yuv2rgb_pkg::luma_gain(tg2_r);
      mb3_r <= yuv2rgb_pkg::luma_gain(tb2_r);
    end
    if (en4) begin
      r4_r <= yuv2rgb_pkg::round_clamp(mr3_r);
      g4_r <= yuv2rgb_pkg::round_clamp(mg3_r);
      b4_r <= yuv2rgb_pkg::round_clamp(mb3_r);
    end
  end

  assign out_word.valid = v4_r;
  assign out_word.red   = r4_r;
  assign out_word.green = g4_r;
  assign out_word.blue  = b4_r;

endmodule

### test/yuv_to_rgb_pixel_tb.sv
`timescale 1ns / 1ps

module yuv_to_rgb_pixel_tb;

  localparam longint V_TO_R    = 89858;
  localparam longint V_TO_G    = -45773;
  localparam longint U_TO_G    = -22014;
  localparam longint U_TO_B    = 113618;
  localparam longint LUMA_GAIN = 76283;
  localparam longint HALF_LSB  = 32768;
  localparam int     PIPE_DEPTH  = 4;
  localparam int     CYCLE_LIMIT = 400000;

  typedef struct packed {
    yuv2rgb_pkg::sample_t red;
    yuv2rgb_pkg::sample_t green;
    yuv2rgb_pkg::sample_t blue;
  } rgb_t;

  logic clk;
  logic rst_n;

  yuv2rgb_in_if  in_word ();
  yuv2rgb_out_if out_word ();

  yuv_to_rgb_pixel dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_word  (in_word),
    .out_word (out_word)
  );

  rgb_t rgb_expected[$];
  int   error_count;
  int   pixels_sent;
  int   pixels_checked;
  int   input_stall_cycles;
  int   cycle_count;
  bit   in_gaps_on;
  bit   out_stalls_on;
  int   hold_request;
  int   hold_left;
  int   stall_left;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic yuv2rgb_pkg::sample_t convert_channel(longint luma_val, longint offset);
    longint level;
    level = ((luma_val + offset - 16) * LUMA_GAIN + HALF_LSB) >>> 16;
    if (level < 0) begin
      return 8'd0;
    end else if (level > 255) begin
      return 8'd255;
    end
    return level[7:0];
  endfunction

  function automatic rgb_t predict_rgb(yuv2rgb_pkg::sample_t y, yuv2rgb_pkg::sample_t u,
                                       yuv2rgb_pkg::sample_t v);
    longint luma_val;
    longint cb;
    longint cr;
    rgb_t   pix;
    luma_val  = longint'(y);
    cb        = longint'(u) - 128;
    cr        = longint'(v) - 128;
    pix.red   = convert_channel(luma_val, (V_TO_R * cr + HALF_LSB) >>> 16);
    pix.green = convert_channel(luma_val, (V_TO_G * cr + U_TO_G * cb + HALF_LSB) >>> 16);
    pix.blue  = convert_channel(luma_val, (U_TO_B * cb + HALF_LSB) >>> 16);
    return pix;
  endfunction

  // mostly short gaps, now and then a long one
  function automatic int pick_gap();
    if ($urandom_range(0, 9) < 9) begin
      return $urandom_range(1, 3);
    end
    return $urandom_range(8, 40);
  endfunction

  function automatic yuv2rgb_pkg::sample_t pick_sample();
    yuv2rgb_pkg::sample_t corners[7] = '{8'd0, 8'd1, 8'd127, 8'd128, 8'd129, 8'd254, 8'd255};
    if ($urandom_range(0, 4) == 0) begin
      return corners[$urandom_range(0, 6)];
    end
    return 8'($urandom_range(0, 255));
  endfunction

  task automatic send_pixel(yuv2rgb_pkg::sample_t y, yuv2rgb_pkg::sample_t u,
                            yuv2rgb_pkg::sample_t v);
    @(negedge clk);
    in_word.valid       = 1'b1;
    in_word.luma        = y;
    in_word.chroma_blue = u;
    in_word.chroma_red  = v;
    forever begin
      @(posedge clk);
      if (in_word.ready) begin
        break;
      end
    end
    rgb_expected.push_back(predict_rgb(y, u, v));
    pixels_sent++;
  endtask

  task automatic idle_input(int cycles);
    repeat (cycles) begin
      @(negedge clk);
      in_word.valid = 1'b0;
    end
  endtask

  task automatic send_random_pixel();
    send_pixel(pick_sample(), pick_sample(), pick_sample());
    if (in_gaps_on && $urandom_range(0, 2) == 0) begin
      idle_input(pick_gap());
    end
  endtask

  task automatic test_extremes();
    yuv2rgb_pkg::sample_t pattern[2] = '{8'h55, 8'haa};
    for (int k = 0; k < 8; k++) begin
      send_pixel(k[0] ? 8'd255 : 8'd0, k[1] ? 8'd255 : 8'd0, k[2] ? 8'd255 : 8'd0);
    end
    // black and white levels, values just outside them and mid grey, all with neutral chroma
    send_pixel(8'd16, 8'd128, 8'd128);
    send_pixel(8'd235, 8'd128, 8'd128);
    send_pixel(8'd15, 8'd128, 8'd128);
    send_pixel(8'd236, 8'd128, 8'd128);
    send_pixel(8'd128, 8'd128, 8'd128);
    // strong chroma pushing channels past both clamps, then near-neutral chroma at low and high luma
    send_pixel(8'd128, 8'd0, 8'd255);
    send_pixel(8'd128, 8'd255, 8'd0);
    send_pixel(8'd20, 8'd127, 8'd129);
    send_pixel(8'd250, 8'd129, 8'd127);
    for (int k = 0; k < 8; k++) begin
      send_pixel(pattern[k[0]], pattern[k[1]], pattern[k[2]]);
    end
    idle_input(1);
  endtask

  task automatic test_back_to_back();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b0;
    repeat (100) begin
      send_random_pixel();
    end
    idle_input(1);
  endtask

  task automatic test_backpressure();
    in_gaps_on    = 1'b0;
    out_stalls_on = 1'b1;
    @(posedge clk);
    hold_request = 60;
    repeat (30) begin
      send_random_pixel();
    end
    idle_input(1);
  endtask

  task automatic test_drain_pause();
    in_gaps_on    = 1'b1;
    out_stalls_on = 1'b1;
    repeat (3) begin
      repeat (8) begin
        send_random_pixel();
      end
      idle_input(1);
      wait (rgb_expected.size() == 0);
    end
  endtask

  task automatic test_random_stream();
    for (int blk = 0; blk < 12; blk++) begin
      in_gaps_on    = (blk % 4) != 3;
      out_stalls_on = (blk % 5) != 2;
      repeat (50) begin
        send_random_pixel();
      end
    end
    idle_input(1);
  endtask

  // receiver side: random stalls plus an occasional long hold-off
  initial begin
    hold_left  = 0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (hold_request > 0) begin
        hold_left    = hold_request;
        hold_request = 0;
      end
      if (hold_left > 0) begin
        out_word.ready = 1'b0;
        hold_left--;
      end else if (!out_stalls_on) begin
        out_word.ready = 1'b1;
      end else if (stall_left > 0) begin
        out_word.ready = 1'b0;
        stall_left--;
      end else if ($urandom_range(0, 3) == 0) begin
        stall_left     = pick_gap() - 1;
        out_word.ready = 1'b0;
      end else begin
        out_word.ready = 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rgb_t want;
    if (rst_n && in_word.valid && !in_word.ready) begin
      input_stall_cycles++;
    end
    if (rst_n && out_word.valid && out_word.ready) begin
      if (rgb_expected.size() == 0) begin
        $error("unexpected word: red %0d green %0d blue %0d",
               out_word.red, out_word.green, out_word.blue);
        error_count++;
      end else begin
        want = rgb_expected.pop_front();
        pixels_checked++;
        if (out_word.red !== want.red) begin
          $error("red: expected %0d, got %0d", want.red, out_word.red);
          error_count++;
        end
        if (out_word.green !== want.green) begin
          $error("green: expected %0d, got %0d", want.green, out_word.green);
          error_count++;
        end
        if (out_word.blue !== want.blue) begin
          $error("blue: expected %0d, got %0d", want.blue, out_word.blue);
          error_count++;
        end
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout with %0d words outstanding", rgb_expected.size());
      $display("yuv_to_rgb_pixel verification failed");
      $finish;
    end
  end

  initial begin
    clk                 = 1'b0;
    rst_n               = 1'b0;
    in_word.valid       = 1'b0;
    in_word.luma        = '0;
    in_word.chroma_blue = '0;
    in_word.chroma_red  = '0;
    out_word.ready      = 1'b0;
    error_count         = 0;
    pixels_sent         = 0;
    pixels_checked      = 0;
    input_stall_cycles  = 0;
    cycle_count         = 0;
    in_gaps_on          = 1'b0;
    out_stalls_on       = 1'b0;
    hold_request        = 0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_extremes();
    test_back_to_back();
    test_backpressure();
    test_drain_pause();
    test_random_stream();

    wait (rgb_expected.size() == 0);
    repeat (4 * PIPE_DEPTH) @(posedge clk);
    $display("sent %0d pixels, checked %0d rgb words, %0d errors", pixels_sent,
             pixels_checked, error_count);
    $display("input held back for %0d cycles under output back-pressure",
             input_stall_cycles);
    if (error_count == 0 && rgb_expected.size() == 0) begin
      $display("yuv_to_rgb_pixel verification clean");
    end else begin
      $display("yuv_to_rgb_pixel verification failed");
    end
    $finish;
  end

endmodule
